>>> hdl/kqo_pkg.sv
package kqo_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int ADDR_W     = $clog2(MAX_FRAMES);
   localparam int CNT_W      = ADDR_W + 1;

   localparam int TIME_W  = 20;
   localparam int COMP_W  = 16;
   localparam int QUAT_W  = 4 * COMP_W;
   localparam int KEY_W   = TIME_W + QUAT_W;
   localparam int FC_W    = 7;
   localparam int INC_W   = 16;
   localparam int T_W     = 17;   // weight 0..65536
   localparam int P_W     = 25;   // lerped component, |p| <= 2^23
   localparam int MUL_W   = 2 * P_W;
   localparam int PR_W    = 48;   // product of two components
   localparam int N_W     = 49;   // sum of four squares
   localparam int E_W     = 51;
   localparam int DIVN_W  = 64;
   localparam int DIVD_W  = N_W;
   localparam int QUO_W   = 16;
   localparam int ENT_N   = 9;

   localparam logic [FC_W-1:0]  FC_RESET  = FC_W'(1);
   localparam logic [INC_W-1:0] INC_RESET = INC_W'(100);
   localparam logic [QUO_W-1:0] ONE_Q14   = QUO_W'(16384);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic CSR_FRAME_COUNT = 1'b0;
   localparam logic CSR_STEP_INC    = 1'b1;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] numer;
      logic [DIVD_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

endpackage

>>> hdl/keyframe_quaternion_orientation_core.sv
// Keyframe orientation core. Load beats (tuser=0) write one keyframe (time,
// Q1.15 quaternion) into the key table. Tick beats (tuser=1) scan the table
// for the interval holding the current step, fetch both keys and the last
// key time, form the weight (by a divide unless it clamps to 0 or 1), lerp,
// and emit the nine Q2.14 rotation-matrix entries of the normalized
// quaternion plus the step used; the step then advances and wraps at the
// last key time. Ticks are dropped while frame_count is zero; it is capped
// at 64. A tick takes the beat, scans the table (one read per cycle),
// fetches the keys, forms the weight, runs the lerp and the products on the
// shared multiplier, sums the norm, computes the nine entries on the one
// bit-serial divider that the weight also uses, and posts the result. A
// finished result waits in the output register while the next beat is taken.
// The key table holds nothing after reset; ticks must only touch loaded slots.
module keyframe_quaternion_orientation_core import kqo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_index[5:0], frame_time[25:6], quat_x[41:26], quat_y[57:42],
   // quat_z[73:58], quat_w[89:74], zero fill
   input  logic [95:0]  req_tdata,
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_0,1,2,4,5,6,8,9,10 at 16 bits each from bit 0, step_used[163:144]
   output logic [167:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_SCAN  = 11'b00000000010,
      ST_FETCH = 11'b00000000100,
      ST_TSET  = 11'b00000001000,
      ST_TDIV  = 11'b00000010000,
      ST_LERP  = 11'b00000100000,
      ST_PROD  = 11'b00001000000,
      ST_NORM  = 11'b00010000000,
      ST_ENTS  = 11'b00100000000,
      ST_ENTW  = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

   // product slots
   localparam int PXX = 0, PYY = 1, PZZ = 2, PWW = 3, PXY = 4;
   localparam int PZW = 5, PXZ = 6, PYW = 7, PYZ = 8, PXW = 9;
   localparam int NPR = 10;

   state_type          state_ff, state_in;
   logic [FC_W-1:0]    fc_ff;
   logic [INC_W-1:0]   inc_ff;
   logic [TIME_W-1:0]  step_ff, step_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [3:0]         ent_ff, ent_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  pidx_ff, pidx_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in;
   logic [TIME_W-1:0]  tc_ff, tc_in, tn_ff, tn_in, tl_ff, tl_in;
   logic [QUAT_W-1:0]  qa_ff, qa_in, qb_ff, qb_in;
   logic [T_W-1:0]     t_ff, t_in;
   logic signed [MUL_W-1:0] prod_ff;
   logic signed [P_W-1:0]   p_ff [4];
   logic signed [P_W-1:0]   p_in [4];
   logic signed [PR_W-1:0]  pr_ff [NPR];
   logic signed [PR_W-1:0]  pr_in [NPR];
   logic [N_W-1:0]     n_ff, n_in;
   logic               eneg_ff, eneg_in;
   logic [QUO_W-1:0]   res_ff [ENT_N];
   logic [QUO_W-1:0]   res_in [ENT_N];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [167:0]       rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [KEY_W-1:0]   ram_rdata;
   logic [TIME_W-1:0]  rd_time;
   logic [QUAT_W-1:0]  rd_quat;

   logic [CNT_W-1:0]   n_frames;
   logic [ADDR_W-1:0]  n_m1, nxt;
   logic               accept;

   logic signed [P_W-1:0]   mul_a, mul_b;
   logic signed [COMP_W:0]  diff;
   logic signed [33:0]      lerp_v;
   logic [33:0]             lerp_mag;
   logic [25:0]             lerp_r;
   logic [1:0]              lc;

   logic signed [TIME_W:0]  num_s, den_s;
   logic [TIME_W-1:0]       an, ad;

   logic signed [E_W-1:0]   e_val, n_s;
   logic [E_W-1:0]          e_mag;
   logic [TIME_W:0]         step_sum;
   logic [QUO_W-1:0]        q_signed;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign ram_we     = accept && (req_tuser == KIND_LOAD)
                       && (CNT_W'(req_tdata[5:0]) < CNT_W'(MAX_FRAMES));
   assign rd_time    = ram_rdata[TIME_W-1:0];
   assign rd_quat    = ram_rdata[KEY_W-1:TIME_W];
   assign n_frames   = (CNT_W'(fc_ff) > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                            : CNT_W'(fc_ff);
   assign n_m1       = ADDR_W'(n_frames - 1'b1);
   assign nxt        = (cur_ff == n_m1) ? '0 : cur_ff + 1'b1;

   kqo_ram #(.WIDTH(KEY_W), .DEPTH(MAX_FRAMES)) u_keys (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_tdata[5:0])),
      .wdata ({req_tdata[89:26], req_tdata[25:6]}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   kqo_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff  <= FC_RESET;
         inc_ff <= INC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_COUNT: fc_ff  <= csr_wdata[FC_W-1:0];
            CSR_STEP_INC:    inc_ff <= csr_wdata[INC_W-1:0];
            default: ;
         endcase
      end
   end

   // weight operands
   assign num_s = signed'({1'b0, step_ff}) - signed'({1'b0, tc_ff});
   assign den_s = signed'({1'b0, tn_ff}) - signed'({1'b0, tc_ff});
   assign an    = num_s[TIME_W] ? TIME_W'(-num_s) : TIME_W'(num_s);
   assign ad    = den_s[TIME_W] ? TIME_W'(-den_s) : TIME_W'(den_s);

   // shared multiplier operands
   assign lc   = cnt_ff[1:0];
   assign diff = signed'({qb_ff[16*lc+15], qb_ff[16*lc +: 16]})
               - signed'({qa_ff[16*lc+15], qa_ff[16*lc +: 16]});

   always_comb begin
      mul_a = P_W'(diff);
      mul_b = signed'(P_W'(t_ff));
      if (state_ff == ST_PROD) begin
         case (cnt_ff)
            4'd0:    begin mul_a = p_ff[0]; mul_b = p_ff[0]; end
            4'd1:    begin mul_a = p_ff[1]; mul_b = p_ff[1]; end
            4'd2:    begin mul_a = p_ff[2]; mul_b = p_ff[2]; end
            4'd3:    begin mul_a = p_ff[3]; mul_b = p_ff[3]; end
            4'd4:    begin mul_a = p_ff[0]; mul_b = p_ff[1]; end
            4'd5:    begin mul_a = p_ff[2]; mul_b = p_ff[3]; end
            4'd6:    begin mul_a = p_ff[0]; mul_b = p_ff[2]; end
            4'd7:    begin mul_a = p_ff[1]; mul_b = p_ff[3]; end
            4'd8:    begin mul_a = p_ff[1]; mul_b = p_ff[2]; end
            default: begin mul_a = p_ff[0]; mul_b = p_ff[3]; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // rounding of the previous lerp product: (a<<16 + d*t) / 256, half away
   always_comb begin
      logic [1:0] pc;
      pc       = lc - 1'b1;
      lerp_v   = (34'(signed'(qa_ff[16*pc +: 16])) <<< 16) + prod_ff[33:0];
      lerp_mag = lerp_v[33] ? 34'(-lerp_v) : 34'(lerp_v);
      lerp_r   = 26'((lerp_mag + 34'd128) >> 8);
   end

   // entry numerator, "1" replaced by N
   always_comb begin
      n_s = signed'(E_W'(n_ff));
      case (ent_ff)
         4'd0:    e_val = n_s - (E_W'(pr_ff[PYY] + E_W'(pr_ff[PZZ])) <<< 1);
         4'd1:    e_val = E_W'(E_W'(pr_ff[PXY]) + E_W'(pr_ff[PZW])) <<< 1;
         4'd2:    e_val = E_W'(E_W'(pr_ff[PXZ]) - E_W'(pr_ff[PYW])) <<< 1;
         4'd3:    e_val = E_W'(E_W'(pr_ff[PXY]) - E_W'(pr_ff[PZW])) <<< 1;
         4'd4:    e_val = n_s - (E_W'(pr_ff[PXX] + E_W'(pr_ff[PZZ])) <<< 1);
         4'd5:    e_val = E_W'(E_W'(pr_ff[PYZ]) + E_W'(pr_ff[PXW])) <<< 1;
         4'd6:    e_val = E_W'(E_W'(pr_ff[PXZ]) + E_W'(pr_ff[PYW])) <<< 1;
         4'd7:    e_val = E_W'(E_W'(pr_ff[PYZ]) - E_W'(pr_ff[PXW])) <<< 1;
         default: e_val = n_s - (E_W'(pr_ff[PXX] + E_W'(pr_ff[PYY])) <<< 1);
      endcase
      e_mag = e_val[E_W-1] ? E_W'(-e_val) : E_W'(e_val);
   end

   assign q_signed = eneg_ff ? QUO_W'(-div_rsp.quot) : div_rsp.quot;
   assign step_sum = {1'b0, step_ff} + (TIME_W+1)'(inc_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      ent_in       = ent_ff;
      addr_in      = addr_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      tc_in        = tc_ff;
      tn_in        = tn_ff;
      tl_in        = tl_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      pr_in        = pr_ff;
      n_in         = n_ff;
      eneg_in      = eneg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_raddr    = addr_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == KIND_TICK) && (fc_ff != '0)) begin
               addr_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b1;
            pidx_in = addr_ff;
            if (addr_ff != n_m1) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (step_ff < rd_time) begin
                  cur_in   = (pidx_ff == '0) ? '0 : pidx_ff - 1'b1;
                  cnt_in   = '0;
                  state_in = ST_FETCH;
               end else if (pidx_ff == n_m1) begin
                  cur_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               4'd0:    ram_raddr = cur_ff;
               4'd1:    ram_raddr = nxt;
               default: ram_raddr = n_m1;
            endcase
            case (cnt_ff)
               4'd1: begin tc_in = rd_time; qa_in = rd_quat; end
               4'd2: begin tn_in = rd_time; qb_in = rd_quat; end
               4'd3: begin tl_in = rd_time; state_in = ST_TSET; end
               default: ;
            endcase
         end
         ST_TSET: begin
            cnt_in = '0;
            if (den_s == '0 || num_s == '0 || (num_s[TIME_W] != den_s[TIME_W])) begin
               t_in     = '0;
               state_in = ST_LERP;
            end else if (an >= ad) begin
               t_in     = T_W'(65536);
               state_in = ST_LERP;
            end else begin
               div_req.start = 1'b1;
               div_req.numer = DIVN_W'(an) << 16;
               div_req.denom = DIVD_W'(ad);
               state_in      = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_rsp.done) begin
               t_in     = T_W'(div_rsp.quot);
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               p_in[lc - 1'b1] = lerp_v[33] ? P_W'(-signed'({1'b0, lerp_r}))
                                            : P_W'(lerp_r);
            end
            if (cnt_ff == 4'd4) begin
               cnt_in   = '0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               pr_in[cnt_ff - 1'b1] = PR_W'(prod_ff);
            end
            if (cnt_ff == 4'(NPR)) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            n_in   = N_W'(pr_ff[PXX]) + N_W'(pr_ff[PYY])
                   + N_W'(pr_ff[PZZ]) + N_W'(pr_ff[PWW]);
            ent_in = '0;
            state_in = ST_ENTS;
         end
         ST_ENTS: begin
            if (n_ff == '0) begin
               // zero-length quaternion: identity
               for (int i = 0; i < ENT_N; i++) begin
                  res_in[i] = '0;
               end
               res_in[0] = ONE_Q14;
               res_in[4] = ONE_Q14;
               res_in[8] = ONE_Q14;
               state_in  = ST_DONE;
            end else begin
               eneg_in       = e_val[E_W-1];
               div_req.start = 1'b1;
               div_req.numer = (DIVN_W'(e_mag) << 14) + DIVN_W'(n_ff >> 1);
               div_req.denom = n_ff;
               state_in      = ST_ENTW;
            end
         end
         ST_ENTW: begin
            if (div_rsp.done) begin
               res_in[ent_ff] = q_signed;
               if (ent_ff == 4'(ENT_N - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  ent_in   = ent_ff + 1'b1;
                  state_in = ST_ENTS;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, step_ff, res_ff[8], res_ff[7], res_ff[6],
                               res_ff[5], res_ff[4], res_ff[3], res_ff[2],
                               res_ff[1], res_ff[0]};
               step_in      = (step_sum >= {1'b0, tl_ff}) ? '0
                                                          : step_sum[TIME_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      cnt_ff      <= cnt_in;
      ent_ff      <= ent_in;
      addr_ff     <= addr_in;
      pidx_ff     <= pidx_in;
      cur_ff      <= cur_in;
      tc_ff       <= tc_in;
      tn_ff       <= tn_in;
      tl_ff       <= tl_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      pr_ff       <= pr_in;
      n_ff        <= n_in;
      eneg_ff     <= eneg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_TDIV || state_ff == ST_ENTW))
      else $error("divider finished outside a wait state");

   a_scan_needs_frames: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (fc_ff != '0))
      else $error("table scan with no frames in use");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished tick");

   a_step_below_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready))
      |=> (step_ff == '0 || step_ff < $past(tl_ff)))
      else $error("step not wrapped at last key time");

endmodule

>>> hdl/kqo_ram.sv
module kqo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/kqo_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees
// numer < denom << QUO_W so the quotient fits.
module kqo_div import kqo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int K_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [DIVN_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DIVN_W-1:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = DIVN_W'(den_ff) << k_ff;
      if (req.start) begin
         busy_in = 1'b1;
         k_in    = K_W'(QUO_W - 1);
         rem_in  = req.numer;
         den_in  = req.denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in       = rem_ff - shifted;
            quo_in[k_ff] = 1'b1;
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule
